// File: hw/rtl/binary_reconstruction_open_close_assert.svh
// Assertion macros for the binary reconstruction block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BINARY_RECONSTRUCTION_OPEN_CLOSE_ASSERT_SVH
`define BINARY_RECONSTRUCTION_OPEN_CLOSE_ASSERT_SVH

// ante in one cycle implies cons in the next
`define BROC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// expression never true
`define BROC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// File: hw/rtl/broc_pkg.sv
// Shared types, constants and row window function for the reconstruction block.
// No dependencies.
`timescale 1ns / 1ps

package broc_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_KERNEL = 15;
  localparam int KERN_HALF  = MAX_KERNEL / 2;
  localparam int ROW_W      = MAX_WIDTH;
  localparam int ADDR_W     = 6;
  localparam int PASS_W     = 13;
  localparam logic [PASS_W-1:0] PASS_LIMIT = 13'd8191;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_MODE   = 3'd0,
    CFG_WIDTH  = 3'd1,
    CFG_HEIGHT = 3'd2,
    CFG_KSIZE  = 3'd3,
    CFG_PRE    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_PASS
  } eng_state_e;

  typedef struct packed {
    logic       mode;
    logic [6:0] width;
    logic [6:0] height;
    logic [3:0] ksize;
    logic [3:0] pre;
  } cfg_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              rd_sel;
    logic [ADDR_W-1:0] rd_row;
    logic [ADDR_W-1:0] src_row;
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_row;
    logic [ROW_W-1:0]  wr_data;
    logic [PASS_W-1:0] passes;
  } eng_ctl_t;

  // Horizontal min (grow=0) or max (grow=1) over one row, outside pixels ignored.
  function automatic logic [ROW_W-1:0] row_win(input logic [ROW_W-1:0] x,
                                               input logic [ROW_W-1:0] wmask,
                                               input logic [3:0] ksize,
                                               input logic grow);
    logic [ROW_W-1:0] xm;
    logic [ROW_W-1:0] sh;
    logic [ROW_W-1:0] fill;
    logic [ROW_W-1:0] acc;
    logic [3:0]       a;
    int               off;
    a   = ksize >> 1;
    xm  = grow ? (x & wmask) : (x | ~wmask);
    acc = grow ? '0 : '1;
    for (int j = 0; j < 2 * KERN_HALF + 1; j++) begin
      off = j - KERN_HALF;
      if (off >= 0) begin
        sh   = xm >> off;
        fill = ~({ROW_W{1'b1}} >> off);
      end else begin
        sh   = xm << (-off);
        fill = ~({ROW_W{1'b1}} << (-off));
      end
      sh = grow ? (sh & ~fill) : (sh | fill);
      if (off >= -int'(a) && off <= int'(ksize) - 1 - int'(a)) begin
        acc = grow ? (acc | sh) : (acc & sh);
      end
    end
    return acc;
  endfunction

endpackage

// File: hw/rtl/binary_reconstruction_open_close.sv
// Binary opening / closing by reconstruction: command decode, row memories, top.
// Depends on broc_pkg, broc_ram, broc_engine and the assertion macro header.
//
// Usage:
//   Commands enter on start/in_* and are transferred at a clock edge with start
//   high and busy low. Write (0) stores in_pixel_in at in_row/in_column of the
//   source image, run (1) computes the configured operation, read (2) returns
//   a pixel of the last result. Command code 3 does nothing but still answers.
//   Every command yields exactly one result: out_valid is high for one cycle
//   with out_pixel_out and out_pass_count; the receiver cannot stall.
//   Latency: write and read answer the cycle after transfer, one command per
//   cycle. A pixel write is a read-modify-write of a 64-bit source row; a
//   write directly following a write to the same row takes that row from a bypass.
//   Run: a copy sweep fills both work buffers from the source image, then each
//   pass, for every row, reads one row per window row and then writes the row,
//   for pre_passes passes plus the reconstruction passes; the result strobe
//   follows the last row write through the engine's done register and the
//   out_valid register, and busy is low again in the strobe cycle.
//   Config: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; write only
//   while the block is idle.
//   Reset (rst_n low, synchronous) restores register defaults and clears the
//   pass count; image memories are not cleared.
`timescale 1ns / 1ps

`include "binary_reconstruction_open_close_assert.svh"

module binary_reconstruction_open_close (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_command,
  input  logic [5:0]                      in_row,
  input  logic [5:0]                      in_column,
  input  logic                            in_pixel_in,
  output logic                            out_valid,
  output logic                            out_pixel_out,
  output logic [broc_pkg::PASS_W-1:0]     out_pass_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [2:0]                      cfg_index,
  input  logic [6:0]                      cfg_data
);

  broc_pkg::cfg_t     cfg_r;
  broc_pkg::eng_ctl_t ctl;

  logic accept;
  logic out_valid_r;
  logic rd_pend_r;
  logic [5:0] col_r;

  // pending pixel write (row read in flight)
  logic       pw_valid_r;
  logic [5:0] pw_row_r;
  logic [5:0] pw_col_r;
  logic       pw_pix_r;
  // last row written, for back-to-back writes to the same row
  logic                       lw_valid_r;
  logic [5:0]                 lw_row_r;
  logic [broc_pkg::ROW_W-1:0] lw_data_r;

  logic [broc_pkg::ROW_W-1:0] src_q, q_a, q_b, q_work, src_base, src_merged;
  logic [5:0]                 src_raddr, wk_raddr;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = ctl.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= 1'b0;
      cfg_r.width  <= 7'd64;
      cfg_r.height <= 7'd64;
      cfg_r.ksize  <= 4'd3;
      cfg_r.pre    <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (broc_pkg::cfg_idx_e'(cfg_index))
        broc_pkg::CFG_MODE:   cfg_r.mode   <= cfg_data[0];
        broc_pkg::CFG_WIDTH:  cfg_r.width  <= cfg_data;
        broc_pkg::CFG_HEIGHT: cfg_r.height <= cfg_data;
        broc_pkg::CFG_KSIZE:  cfg_r.ksize  <= cfg_data[3:0];
        broc_pkg::CFG_PRE:    cfg_r.pre    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // command pipeline: every non-run command answers next cycle, run answers from the engine's done via out_valid_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      pw_valid_r  <= 1'b0;
      lw_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= (accept && in_command != broc_pkg::CMD_RUN) || ctl.done;
      rd_pend_r   <= accept && in_command == broc_pkg::CMD_READ;
      pw_valid_r  <= accept && in_command == broc_pkg::CMD_WRITE;
      lw_valid_r  <= pw_valid_r;
    end
    col_r     <= in_column;
    pw_row_r  <= in_row;
    pw_col_r  <= in_column;
    pw_pix_r  <= in_pixel_in;
    lw_row_r  <= pw_row_r;
    lw_data_r <= src_merged;
  end

  always_comb begin
    src_base = (lw_valid_r && lw_row_r == pw_row_r) ? lw_data_r : src_q;
    src_merged = src_base;
    src_merged[pw_col_r] = pw_pix_r;
  end

  assign src_raddr = ctl.busy ? ctl.src_row : in_row;
  assign wk_raddr  = ctl.busy ? ctl.rd_row : in_row;
  assign q_work    = ctl.rd_sel ? q_b : q_a;

  broc_ram #(.WIDTH(broc_pkg::ROW_W), .DEPTH(broc_pkg::MAX_HEIGHT)) u_src_ram (
    .clk   (clk),
    .we    (pw_valid_r),
    .waddr (pw_row_r),
    .wdata (src_merged),
    .raddr (src_raddr),
    .rdata (src_q)
  );

  broc_ram #(.WIDTH(broc_pkg::ROW_W), .DEPTH(broc_pkg::MAX_HEIGHT)) u_work_a (
    .clk   (clk),
    .we    (ctl.wr_a),
    .waddr (ctl.wr_row),
    .wdata (ctl.wr_data),
    .raddr (wk_raddr),
    .rdata (q_a)
  );

  broc_ram #(.WIDTH(broc_pkg::ROW_W), .DEPTH(broc_pkg::MAX_HEIGHT)) u_work_b (
    .clk   (clk),
    .we    (ctl.wr_b),
    .waddr (ctl.wr_row),
    .wdata (ctl.wr_data),
    .raddr (wk_raddr),
    .rdata (q_b)
  );

  broc_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (accept && in_command == broc_pkg::CMD_RUN),
    .cfg   (cfg_r),
    .src_q (src_q),
    .wk_q  (q_work),
    .ctl   (ctl)
  );

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = rd_pend_r & q_work[col_r];
  assign out_pass_count = ctl.passes;

  // non-run commands answer in the next cycle
  `BROC_ASSERT_NEXT(a_cmd_answer, start && !busy && in_command != broc_pkg::CMD_RUN, out_valid, "command without result")
  // a run holds busy and gives no immediate result
  `BROC_ASSERT_NEXT(a_run_busy, start && !busy && in_command == broc_pkg::CMD_RUN, busy && !out_valid, "run not busy")
  // source row update never overlaps a run
  `BROC_ASSERT_NEVER(a_src_wr_run, pw_valid_r && busy, "source write during run")

endmodule

// File: hw/rtl/broc_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module broc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/broc_engine.sv
// Run sequencer: copy, pre-passes and reconstruction passes over row memories.
// Depends on broc_pkg; memories live in the top level.
`timescale 1ns / 1ps

module broc_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  broc_pkg::cfg_t                cfg,
  input  logic [broc_pkg::ROW_W-1:0]    src_q,
  input  logic [broc_pkg::ROW_W-1:0]    wk_q,
  output broc_pkg::eng_ctl_t            ctl
);

  broc_pkg::eng_state_e state_r, state_nxt;
  logic [6:0]                      cnt_r, cnt_nxt;
  logic [broc_pkg::ADDR_W-1:0]     row_r, row_nxt;
  logic [3:0]                      step_r, step_nxt;
  logic                            rv_r, rv_nxt;
  logic [broc_pkg::ROW_W-1:0]      acc_r, acc_nxt;
  logic [broc_pkg::ROW_W-1:0]      cur_r, cur_nxt;
  logic [3:0]                      pp_r, pp_nxt;
  logic                            recon_r, recon_nxt;
  logic                            any_r, any_nxt;
  logic                            chg_r, chg_nxt;
  logic                            sel_r, sel_nxt;
  logic                            done_r, done_nxt;
  logic [broc_pkg::PASS_W-1:0]     passes_r, passes_nxt;

  logic [6:0]                 w_e, h_e;
  logic [3:0]                 k_e, a_e, pp_dec;
  logic [broc_pkg::ROW_W-1:0] wmask, hw, acc_base, acc_in, curv, val, cdata;
  logic                       grow, cap, any_fin, chg_fin;
  logic signed [8:0]          rr;
  logic                       rr_ok;

  function automatic logic [6:0] clamp_dim(input logic [6:0] v, input logic [6:0] lim);
    logic [6:0] r;
    r = v;
    if (v == 7'd0) r = 7'd1;
    else if (v > lim) r = lim;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= broc_pkg::ST_IDLE;
      done_r   <= 1'b0;
      passes_r <= '0;
      sel_r    <= 1'b0;
      rv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      done_r   <= done_nxt;
      passes_r <= passes_nxt;
      sel_r    <= sel_nxt;
      rv_r     <= rv_nxt;
    end
    cnt_r   <= cnt_nxt;
    row_r   <= row_nxt;
    step_r  <= step_nxt;
    acc_r   <= acc_nxt;
    cur_r   <= cur_nxt;
    pp_r    <= pp_nxt;
    recon_r <= recon_nxt;
    any_r   <= any_nxt;
    chg_r   <= chg_nxt;
  end

  always_comb begin
    w_e   = clamp_dim(cfg.width, 7'(broc_pkg::MAX_WIDTH));
    h_e   = clamp_dim(cfg.height, 7'(broc_pkg::MAX_HEIGHT));
    k_e   = (cfg.ksize == 4'd0) ? 4'd1 : cfg.ksize;
    a_e   = k_e >> 1;
    wmask = (w_e >= 7'(broc_pkg::ROW_W)) ? '1
          : ((broc_pkg::ROW_W'(1) << w_e) - broc_pkg::ROW_W'(1));
    grow  = recon_r ? ~cfg.mode : cfg.mode;
    hw    = broc_pkg::row_win(wk_q, wmask, k_e, grow);

    rr    = $signed({3'b000, row_r}) + $signed({5'b00000, step_r})
          - $signed({5'b00000, a_e});
    rr_ok = !rr[8] && (rr[7:0] < {1'b0, h_e});

    acc_base = (step_r == 4'd0) ? (grow ? '0 : '1) : acc_r;
    acc_in   = !rv_r ? acc_base : (grow ? (acc_base | hw) : (acc_base & hw));
    cap      = (step_r != 4'd0) && ((step_r - 4'd1) == a_e);
    curv     = cap ? wk_q : cur_r;
    if (!recon_r) val = acc_in & wmask;
    else if (cfg.mode) val = (acc_in | src_q) & wmask;
    else val = acc_in & src_q & wmask;
    cdata   = ({1'b0, cnt_r - 7'd1} < {1'b0, h_e}) ? (src_q & wmask) : '0;
    any_fin = any_r | (val != '0);
    chg_fin = chg_r | (val != curv);
    pp_dec  = pp_r - 4'd1;

    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    row_nxt    = row_r;
    step_nxt   = step_r;
    rv_nxt     = 1'b0;
    acc_nxt    = acc_r;
    cur_nxt    = cur_r;
    pp_nxt     = pp_r;
    recon_nxt  = recon_r;
    any_nxt    = any_r;
    chg_nxt    = chg_r;
    sel_nxt    = sel_r;
    done_nxt   = 1'b0;
    passes_nxt = passes_r;

    ctl.busy    = (state_r != broc_pkg::ST_IDLE) || done_r;
    ctl.done    = done_r;
    ctl.rd_sel  = sel_r;
    ctl.rd_row  = rr[broc_pkg::ADDR_W-1:0];
    ctl.src_row = row_r;
    ctl.wr_a    = 1'b0;
    ctl.wr_b    = 1'b0;
    ctl.wr_row  = row_r;
    ctl.wr_data = val;
    ctl.passes  = passes_r;

    case (state_r)
      broc_pkg::ST_IDLE: begin
        if (go) begin
          state_nxt  = broc_pkg::ST_COPY;
          cnt_nxt    = 7'd0;
          any_nxt    = 1'b0;
          passes_nxt = '0;
        end
      end
      broc_pkg::ST_COPY: begin
        // read source row cnt, write row cnt-1 into both work buffers
        ctl.src_row = cnt_r[broc_pkg::ADDR_W-1:0];
        ctl.wr_row  = 6'(cnt_r - 7'd1);
        ctl.wr_data = cdata;
        cnt_nxt     = cnt_r + 7'd1;
        if (cnt_r != 7'd0) begin
          ctl.wr_a = 1'b1;
          ctl.wr_b = 1'b1;
          any_nxt  = any_r | (cdata != '0);
        end
        if (cnt_r == 7'(broc_pkg::MAX_HEIGHT)) begin
          row_nxt  = '0;
          step_nxt = '0;
          sel_nxt  = 1'b0;
          chg_nxt  = 1'b0;
          pp_nxt   = cfg.pre;
          if (cfg.pre != 4'd0) begin
            state_nxt = broc_pkg::ST_PASS;
            recon_nxt = 1'b0;
            any_nxt   = 1'b0;
          end else if (any_nxt) begin
            state_nxt = broc_pkg::ST_PASS;
            recon_nxt = 1'b1;
          end else begin
            state_nxt = broc_pkg::ST_IDLE;
            done_nxt  = 1'b1;
          end
        end
      end
      broc_pkg::ST_PASS: begin
        rv_nxt  = (step_r < k_e) && rr_ok;
        acc_nxt = acc_in;
        if (cap) cur_nxt = wk_q;
        if (step_r == k_e) begin
          ctl.wr_a = sel_r;
          ctl.wr_b = ~sel_r;
          any_nxt  = any_fin;
          chg_nxt  = chg_fin;
          step_nxt = 4'd0;
          row_nxt  = row_r + 6'd1;
          if ({1'b0, row_r} == h_e - 7'd1) begin
            // end of sweep
            sel_nxt = ~sel_r;
            row_nxt = '0;
            any_nxt = 1'b0;
            chg_nxt = 1'b0;
            if (!recon_r) begin
              pp_nxt = pp_dec;
              if (pp_dec != 4'd0) begin
                recon_nxt = 1'b0;
              end else if (any_fin) begin
                recon_nxt = 1'b1;
              end else begin
                state_nxt = broc_pkg::ST_IDLE;
                done_nxt  = 1'b1;
              end
            end else begin
              if (passes_r != broc_pkg::PASS_LIMIT) passes_nxt = passes_r + 13'd1;
              if (!chg_fin) begin
                state_nxt = broc_pkg::ST_IDLE;
                done_nxt  = 1'b1;
              end
            end
          end
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      default: begin
        state_nxt = broc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
